// File: src/postfix_add_mul_evaluator_core_defines.svh
// assertion macros for the checker file
`ifndef POSTFIX_ADD_MUL_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_ADD_MUL_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define PFX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// next-cycle implication, held off during reset
`define PFX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

// File: src/pfx_eval_pkg.sv
package pfx_eval_pkg;

    // field widths
    localparam int VALUE_W = 12;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    // default stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // register reset
    localparam logic [VALUE_W-1:0] LIMIT_RST = 12'hfff;

    // action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

endpackage

// File: src/postfix_add_mul_evaluator_core.sv
// Postfix evaluator for '+' and '*' over single decimal digits. One character or end item
// is taken per cycle, back to back; an end item passes through the input register, then
// the result register, and character items keep flowing while a result waits on a stalled
// output, while an end item waits in the input register and stalls the input until the
// output is free. The top two stack values live in registers and the entry below them is
// prefetched from the stack memory every cycle, so an add or a 12-bit multiply on the top
// pair is computed combinationally from registers. Errors (operator with fewer than two
// values, result above the limit, push onto a full stack) stick until the end item, which
// reports value 0 with error set, as does an end item on an empty stack. The limit register
// is always ready and may be written only while the block is idle.
module postfix_add_mul_evaluator_core #(
    parameter int STACK_DEPTH = pfx_eval_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic [pfx_eval_pkg::CHAR_W-1:0]   i_character,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pfx_eval_pkg::VALUE_W-1:0]  o_value,
    output logic                              o_error,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pfx_eval_pkg::VALUE_W-1:0]  i_cfg_limit
);

    localparam int VW    = pfx_eval_pkg::VALUE_W;
    localparam int CW    = pfx_eval_pkg::CHAR_W;
    localparam int DW    = pfx_eval_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

    // configuration
    logic [VW-1:0]    r_limit;

    // input register
    logic             r_in_valid;
    logic             r_in_action;
    logic [CW-1:0]    r_in_char;

    // stack state
    logic [VW-1:0]    r_mem [STACK_DEPTH];
    logic [VW-1:0]    r_top;
    logic [VW-1:0]    r_nos;
    logic [VW-1:0]    r_third;
    logic [CNT_W-1:0] r_count;
    logic             r_err;
    logic [VW-1:0]    n_top;
    logic [VW-1:0]    n_nos;
    logic [CNT_W-1:0] n_count;
    logic             n_err;

    // result register
    logic             r_out_valid;
    logic [VW-1:0]    r_out_value;
    logic             r_out_error;

    // datapath
    logic             out_free;
    logic             proc_fire;
    logic             end_fire;
    logic             in_load;
    logic             is_digit;
    logic             is_plus;
    logic             is_star;
    logic [DW-1:0]    digit;
    logic [VW:0]      sum;
    logic [2*VW-1:0]  prod;
    logic             res_big;
    logic [VW-1:0]    res;
    logic             push_ok;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             end_err;

    // handshake control
    assign out_free    = !r_out_valid || !i_stall;
    assign proc_fire   = r_in_valid && ((r_in_action == pfx_eval_pkg::ACT_CHAR) || out_free);
    assign end_fire    = proc_fire && (r_in_action == pfx_eval_pkg::ACT_END);
    assign in_load     = !r_in_valid || proc_fire;
    assign o_stall     = r_in_valid && !proc_fire;
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_error     = r_out_error;
    assign o_cfg_ready = 1'b1;

    // character decode
    assign is_digit = (r_in_char >= pfx_eval_pkg::CHAR_ZERO)
                   && (r_in_char <= pfx_eval_pkg::CHAR_NINE);
    assign is_plus  = (r_in_char == pfx_eval_pkg::CHAR_PLUS);
    assign is_star  = (r_in_char == pfx_eval_pkg::CHAR_STAR);
    assign digit    = DW'(r_in_char - pfx_eval_pkg::CHAR_ZERO);

    // operator on the top pair
    assign sum     = {1'b0, r_nos} + {1'b0, r_top};
    assign prod    = r_nos * r_top;
    assign res_big = is_plus ? (sum > {1'b0, r_limit})
                             : (prod > {{VW{1'b0}}, r_limit});
    assign res     = is_plus ? sum[VW-1:0] : prod[VW-1:0];

    // end result
    assign end_err = r_err || (r_count == '0);

    // next stack state
    always_comb begin
        n_top   = r_top;
        n_nos   = r_nos;
        n_count = r_count;
        n_err   = r_err;
        push_ok = 1'b0;
        if (proc_fire) begin
            if (r_in_action == pfx_eval_pkg::ACT_END) begin
                n_count = '0;
                n_err   = 1'b0;
            end else if (!r_err) begin
                if (is_digit) begin
                    if (r_count == CNT_FULL) begin
                        n_err = 1'b1;
                    end else begin
                        push_ok = 1'b1;
                        n_top   = {{(VW-DW){1'b0}}, digit};
                        n_nos   = r_top;
                        n_count = r_count + CNT_ONE;
                    end
                end else if (is_plus || is_star) begin
                    if (r_count < CNT_TWO || res_big) begin
                        n_err = 1'b1;
                    end else begin
                        n_top   = res;
                        n_nos   = r_third;
                        n_count = r_count - CNT_ONE;
                    end
                end
            end
        end
    end

    // spill the old second entry on a push, prefetch the entry under the new second
    assign mem_we  = push_ok && (r_count >= CNT_TWO);
    assign wr_addr = AW'(r_count - CNT_TWO);
    assign rd_addr = AW'(n_count - CNT_THREE);

    // stack memory with registered read, forwarded on a push
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_nos;
        end
        if (push_ok) begin
            r_third <= r_nos;
        end else begin
            r_third <= r_mem[rd_addr];
        end
    end

    // top pair
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_nos <= n_nos;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= pfx_eval_pkg::LIMIT_RST;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= end_fire;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_limit;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_action <= i_action;
            r_in_char   <= i_character;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_value <= end_err ? '0 : r_top;
            r_out_error <= end_err;
        end
    end

endmodule

// File: src/pfx_eval_checker.sv
`include "postfix_add_mul_evaluator_core_defines.svh"

module pfx_eval_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              i_action,
    input logic [pfx_eval_pkg::CHAR_W-1:0]   i_character,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [pfx_eval_pkg::VALUE_W-1:0]  o_value,
    input logic                              o_error,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);

    // a stalled result stays put
    `PFX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_error))

    // an error result carries a zero value
    `PFX_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_error, o_value == '0)

    // input never stalls while the result side can take a transfer
    `PFX_ASSERT_NOW(a_no_stall, i_clk, i_rst_n, !o_valid || !i_stall, !o_stall)

    // a stalled input transfer stays put
    `PFX_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable({i_action, i_character}))

    // register writes are always taken
    `PFX_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind postfix_add_mul_evaluator_core pfx_eval_checker u_pfx_eval_checker (.*);

// File: verif/postfix_add_mul_evaluator_core_tb.sv
`timescale 1ns / 100ps

module postfix_add_mul_evaluator_core_tb;

    localparam int DEPTH          = pfx_eval_pkg::STACK_DEPTH_DEF;
    localparam int CW             = pfx_eval_pkg::CHAR_W;
    localparam int VW             = pfx_eval_pkg::VALUE_W;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    // characters the block passes over
    localparam logic [CW-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CW-1:0] CHAR_HIGH  = 8'hff;

    typedef struct {
        logic          action;
        logic [CW-1:0] ch;
        bit            hold;
    } t_char_item;

    typedef struct {
        logic [VW-1:0] value;
        logic          error;
    } t_eval_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic          i_action = pfx_eval_pkg::ACT_CHAR;
    logic [CW-1:0] i_character = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [VW-1:0] o_value;
    logic          o_error;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [VW-1:0] i_cfg_limit = pfx_eval_pkg::LIMIT_RST;

    // stimulus and expected results
    t_char_item   pending_chars[$];
    t_eval_result expected_results[$];
    int           queued_count = 0;
    int           accepted_count = 0;
    int           phase_weight = 0;
    bit           hold_next = 1'b0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           fail_count = 0;

    // predicted evaluator state
    logic [VW-1:0] eval_stack[DEPTH];
    int            eval_depth = 0;
    bit            eval_fault = 1'b0;
    logic [VW-1:0] eval_limit = pfx_eval_pkg::LIMIT_RST;

    postfix_add_mul_evaluator_core #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_character(i_character),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_error    (o_error),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_limit(i_cfg_limit)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_digit(logic [CW-1:0] ch);
        return (ch >= pfx_eval_pkg::CHAR_ZERO) && (ch <= pfx_eval_pkg::CHAR_NINE);
    endfunction

    function automatic bit is_operator(logic [CW-1:0] ch);
        return (ch == pfx_eval_pkg::CHAR_PLUS) || (ch == pfx_eval_pkg::CHAR_STAR);
    endfunction

    function automatic logic [CW-1:0] digit_char(int d);
        return CW'(pfx_eval_pkg::CHAR_ZERO + d);
    endfunction

    function automatic logic [CW-1:0] random_operator();
        return ($urandom_range(1) == 1) ? pfx_eval_pkg::CHAR_PLUS : pfx_eval_pkg::CHAR_STAR;
    endfunction

    // any byte that is neither a digit nor an operator
    function automatic logic [CW-1:0] noise_char();
        logic [CW-1:0] c;
        do begin
            c = CW'($urandom_range(255));
        end while (is_digit(c) || is_operator(c));
        return c;
    endfunction

    // advance the predicted stack by one transferred item
    task automatic evaluate_item(input logic act, input logic [CW-1:0] ch);
        int unsigned  lhs;
        int unsigned  rhs;
        int unsigned  res;
        t_eval_result r;
        if (act == pfx_eval_pkg::ACT_END) begin
            if (eval_fault || eval_depth == 0) begin
                r.value = '0;
                r.error = 1'b1;
            end else begin
                r.value = eval_stack[eval_depth - 1];
                r.error = 1'b0;
            end
            expected_results.push_back(r);
            eval_depth = 0;
            eval_fault = 1'b0;
        end else if (!eval_fault) begin
            if (is_digit(ch)) begin
                if (eval_depth >= DEPTH) begin
                    eval_fault = 1'b1;
                end else begin
                    eval_stack[eval_depth] = VW'(ch - pfx_eval_pkg::CHAR_ZERO);
                    eval_depth++;
                end
            end else if (is_operator(ch)) begin
                if (eval_depth < 2) begin
                    eval_fault = 1'b1;
                end else begin
                    rhs = eval_stack[eval_depth - 1];
                    lhs = eval_stack[eval_depth - 2];
                    eval_depth -= 2;
                    res = (ch == pfx_eval_pkg::CHAR_PLUS) ? lhs + rhs : lhs * rhs;
                    if (res > eval_limit) begin
                        eval_fault = 1'b1;
                    end else begin
                        eval_stack[eval_depth] = VW'(res);
                        eval_depth++;
                    end
                end
            end
        end
    endtask

    task automatic queue_char(input logic act, input logic [CW-1:0] ch);
        t_char_item it;
        it.action = act;
        it.ch     = ch;
        it.hold   = hold_next;
        hold_next = 1'b0;
        pending_chars.push_back(it);
        queued_count++;
        phase_weight++;
    endtask

    task automatic queue_end();
        queue_char(pfx_eval_pkg::ACT_END, CW'($urandom_range(255)));
    endtask

    // one random expression: mostly well formed, some broken, some too deep
    task automatic queue_expression();
        int kind;
        int leaves;
        int pushed;
        int level;
        int len;
        int pick;
        kind = $urandom_range(99);
        hold_next = ($urandom_range(99) < 3);
        if (kind < 70) begin
            leaves = ($urandom_range(9) == 0) ? $urandom_range(9, DEPTH) : $urandom_range(1, 6);
            pushed = 0;
            level  = 0;
            while (pushed < leaves || level > 1) begin
                if ($urandom_range(9) == 0)
                    queue_char(pfx_eval_pkg::ACT_CHAR, noise_char());
                if (level >= 2 && (pushed == leaves || $urandom_range(1) == 1)) begin
                    queue_char(pfx_eval_pkg::ACT_CHAR, random_operator());
                    level--;
                end else begin
                    queue_char(pfx_eval_pkg::ACT_CHAR, digit_char($urandom_range(9)));
                    level++;
                    pushed++;
                end
            end
            queue_end();
        end else if (kind < 88) begin
            len = $urandom_range(10);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(3);
                case (pick)
                    0:       queue_char(pfx_eval_pkg::ACT_CHAR, digit_char($urandom_range(9)));
                    1:       queue_char(pfx_eval_pkg::ACT_CHAR, random_operator());
                    2:       queue_char(pfx_eval_pkg::ACT_CHAR, noise_char());
                    default: queue_char(pfx_eval_pkg::ACT_CHAR, CW'($urandom_range(255)));
                endcase
            end
            if ($urandom_range(3) != 0)
                queue_end();
        end else begin
            len = $urandom_range(DEPTH - 1, DEPTH + 2);
            for (int i = 0; i < len; i++)
                queue_char(pfx_eval_pkg::ACT_CHAR, digit_char($urandom_range(9)));
            len = $urandom_range(2);
            for (int i = 0; i < len; i++)
                queue_char(pfx_eval_pkg::ACT_CHAR, random_operator());
            queue_end();
        end
    endtask

    task automatic queue_random(input int weight);
        phase_weight = 0;
        while (phase_weight < weight)
            queue_expression();
    endtask

    // wait until every item is through and every result is back
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write over the configuration channel
    task automatic write_limit(input logic [VW-1:0] limit);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_limit <= limit;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eval_limit = limit;
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // input driver: presents queued characters, predicts on each transfer
    always @(posedge i_clk) begin : drive_chars
        t_char_item nxt;
        logic       next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                evaluate_item(i_action, i_character);
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_chars.size() != 0) begin
                nxt = pending_chars[0];
                if (!(nxt.hold && expected_results.size() != 0) &&
                    $urandom_range(99) >= gap_pct) begin
                    void'(pending_chars.pop_front());
                    i_action    <= nxt.action;
                    i_character <= nxt.ch;
                    next_valid  = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    // result monitor: compares each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_eval_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result (value)", -1, o_value);
                end else begin
                    want = expected_results.pop_front();
                    if (o_value !== want.value)
                        report_mismatch("value", want.value, o_value);
                    if (o_error !== want.error)
                        report_mismatch("error", want.error, o_error);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no transfer anywhere
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) === 1'b1 || (o_valid && !i_stall) === 1'b1 ||
                (i_cfg_valid && o_cfg_ready) === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("postfix_add_mul_evaluator_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks at the reset limit
        gap_pct   = 18;
        stall_pct = 79;
        // end on an empty stack
        queue_end();
        // zero result with an ignored byte in between
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(0));
        queue_char(pfx_eval_pkg::ACT_CHAR, CHAR_HIGH);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_end();
        // operator short of operands
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_PLUS);
        queue_end();
        // (9+4)*7*5*9 lands exactly on the limit, sent once all results are back
        hold_next = 1'b1;
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(4));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_PLUS);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(7));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(5));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_end();
        // product over the limit, then a digit that must be ignored
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_STAR);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(5));
        queue_end();
        wait_idle();

        // zero limit: digits still push, any nonzero operator result faults
        write_limit('0);
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(9));
        queue_char(pfx_eval_pkg::ACT_CHAR, CHAR_SPACE);
        queue_end();
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(1));
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(1));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_PLUS);
        queue_end();
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(0));
        queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(0));
        queue_char(pfx_eval_pkg::ACT_CHAR, pfx_eval_pkg::CHAR_PLUS);
        queue_end();
        queue_random(150);
        wait_idle();

        // full limit, push past the stack depth first
        write_limit(pfx_eval_pkg::LIMIT_RST);
        for (int i = 0; i <= DEPTH; i++)
            queue_char(pfx_eval_pkg::ACT_CHAR, digit_char(1));
        queue_end();
        queue_random(200);
        wait_idle();

        // receiver mostly ready, sender gappy
        gap_pct   = 79;
        stall_pct = 18;
        write_limit(VW'(81));
        queue_random(200);
        wait_idle();

        write_limit(VW'($urandom_range(4095)));
        queue_random(200);
        wait_idle();

        // back to back on both sides
        gap_pct   = 0;
        stall_pct = 0;
        write_limit(VW'(9));
        queue_random(150);
        wait_idle();

        write_limit(pfx_eval_pkg::LIMIT_RST);
        queue_random(180);
        wait_idle();

        if (fail_count == 0)
            $display("postfix_add_mul_evaluator_core regression: pass");
        else
            $display("postfix_add_mul_evaluator_core regression: fail");
        $finish;
    end

endmodule
